// File: src/aopt_pkg.sv
// Shared types and constants for the auto-off power timer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package aopt_pkg;

	localparam int MS_PER_SECOND = 1000;
	localparam int MS_W          = 10;
	localparam int SEC_W         = 16;
	localparam int DLY_W         = MS_W + 1;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 16;

	localparam logic [MS_W-1:0]  DEBOUNCE_MS_RST  = MS_W'(50);
	localparam logic [SEC_W-1:0] WARN_SECONDS_RST = SEC_W'(25 * 60);
	localparam logic [SEC_W-1:0] OFF_SECONDS_RST  = SEC_W'(30 * 60);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DEBOUNCE_MS  = 2'd0,
		CFG_WARN_SECONDS = 2'd1,
		CFG_OFF_SECONDS  = 2'd2
	} aopt_cfg_idx_t;

	typedef struct packed {
		logic [MS_W-1:0]  debounce_ms;
		logic [SEC_W-1:0] warn_seconds;
		logic [SEC_W-1:0] off_seconds;
	} aopt_cfg_t;

	typedef struct packed {
		logic press_seen;
		logic warn_on;
		logic power_on;
	} aopt_result_t;

endpackage

// File: src/auto_off_power_timer.sv
// Top level of the auto-off power timer: stream ports, input and result registers.
// Depends on aopt_pkg, aopt_cfg and aopt_core.
`timescale 1ns / 1ps

// One input transfer is one millisecond tick carrying the raw button level;
// each tick yields exactly one result transfer with the power switch, the
// warning light and a press flag. A tick can be taken every clock cycle while
// the output side is not stalled: it lands in an input register, the step
// logic runs in one pass, and the result is held in an output register until
// the output side takes it. cfg_ready is always high; a write to index 3 is
// ignored. Write configuration only while no tick is in flight.
module auto_off_power_timer (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [7:0]                      s_axis_tdata,  // [0] button_down
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [7:0]                      m_axis_tdata,  // [0] power_on, [1] warn_on,
	                                                       // [2] press_seen
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [aopt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [aopt_pkg::CFG_DATA_W-1:0] cfg_data
);
	import aopt_pkg::*;

	aopt_cfg_t    cfg;
	aopt_result_t res, res_q;
	logic         valid_s1, level_s1, out_valid_q, advance;

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'b0, res_q.press_seen, res_q.warn_on, res_q.power_on};

	aopt_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	aopt_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.level  (level_s1),
		.cfg    (cfg),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready)
			level_s1 <= s_axis_tdata[0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_q <= res;
	end

endmodule

// File: src/aopt_cfg.sv
// Configuration register file for the auto-off power timer.
// Depends on aopt_pkg.
`timescale 1ns / 1ps

module aopt_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [aopt_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [aopt_pkg::CFG_DATA_W-1:0]   cfg_data,
	output aopt_pkg::aopt_cfg_t               cfg
);
	import aopt_pkg::*;

	aopt_cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms  <= DEBOUNCE_MS_RST;
			cfg_q.warn_seconds <= WARN_SECONDS_RST;
			cfg_q.off_seconds  <= OFF_SECONDS_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_DEBOUNCE_MS:  cfg_q.debounce_ms  <= cfg_data[MS_W-1:0];
				CFG_WARN_SECONDS: cfg_q.warn_seconds <= cfg_data[SEC_W-1:0];
				CFG_OFF_SECONDS:  cfg_q.off_seconds  <= cfg_data[SEC_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

// File: src/aopt_core.sv
// Timer state and single-pass step logic: timebase, debounce, press and timeout.
// Depends on aopt_pkg; configuration comes from aopt_cfg.
`timescale 1ns / 1ps

module aopt_core (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  logic                   level,
	input  aopt_pkg::aopt_cfg_t    cfg,
	output aopt_pkg::aopt_result_t res
);
	import aopt_pkg::*;

	logic [MS_W-1:0]  ms_q, ms_plus, ms_d, dbs_q, dbs_d;
	logic [SEC_W-1:0] sec_q, sec_d, start_q, start_d, elapsed;
	logic             stable_q, stable_d, deb_q, deb_d;
	logic             power_q, power_d, warn_q, warn_d;
	logic             ms_wrap, changed, press;
	logic [DLY_W-1:0] delay;

	always_comb begin
		ms_plus = ms_q + MS_W'(1);
		ms_wrap = ms_plus >= MS_W'(MS_PER_SECOND);
		ms_d    = ms_wrap ? '0 : ms_plus;
		sec_d   = sec_q + SEC_W'(ms_wrap);

		changed  = level != stable_q;
		stable_d = level;
		dbs_d    = dbs_q;
		deb_d    = deb_q;
		press    = 1'b0;
		if (ms_d >= dbs_q)
			delay = {1'b0, ms_d} - {1'b0, dbs_q};
		else
			delay = {1'b0, ms_d} + DLY_W'(MS_PER_SECOND) - {1'b0, dbs_q};
		if (changed) begin
			dbs_d = ms_d;
			deb_d = 1'b1;
		end else if (deb_q && delay >= {1'b0, cfg.debounce_ms}) begin
			deb_d = 1'b0;
			press = level;
		end

		power_d = power_q;
		warn_d  = warn_q;
		start_d = start_q;
		elapsed = sec_d - start_q;
		if (press) begin
			if (!power_q) begin
				start_d = sec_d;
				power_d = 1'b1;
			end else if (warn_q) begin
				start_d = sec_d;
				warn_d  = 1'b0;
			end else begin
				power_d = 1'b0;
				warn_d  = 1'b0;
			end
		end else if (power_q) begin
			if (elapsed >= cfg.off_seconds) begin
				power_d = 1'b0;
				warn_d  = 1'b0;
			end else if (!warn_q && elapsed >= cfg.warn_seconds) begin
				warn_d = 1'b1;
			end
		end

		res.power_on   = power_d;
		res.warn_on    = warn_d;
		res.press_seen = press;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ms_q     <= '0;
			sec_q    <= '0;
			stable_q <= 1'b0;
			dbs_q    <= '0;
			deb_q    <= 1'b0;
			power_q  <= 1'b0;
			warn_q   <= 1'b0;
			start_q  <= '0;
		end else if (step) begin
			ms_q     <= ms_d;
			sec_q    <= sec_d;
			stable_q <= stable_d;
			dbs_q    <= dbs_d;
			deb_q    <= deb_d;
			power_q  <= power_d;
			warn_q   <= warn_d;
			start_q  <= start_d;
		end
	end

`ifndef SYNTHESIS
	a_warn_needs_power: assert property (@(posedge clk) disable iff (!arst_n)
		warn_q |-> power_q)
		else $error("warn lit while power is off");
	a_ms_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ms_q < MS_W'(MS_PER_SECOND))
		else $error("millisecond count out of range");
	a_hold_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(ms_q) && $stable(sec_q) && $stable(power_q))
		else $error("timer state moved without a tick");
	a_press_toggles: assert property (@(posedge clk) disable iff (!arst_n)
		step && press && !power_q |=> power_q && !warn_q)
		else $error("press with power off did not turn power on");
`endif

endmodule
